FILE: hdl/tsv_pkg.sv
// Shared definitions for the trilinear volume sampler: grid defaults, codes,
// register reset values and the control word that rides down the pipeline.
// No dependencies.
package tsv_pkg;

  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;
  localparam int GRID_Z_DEF = 16;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int VOXEL_W   = 2 * SAMPLE_W;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [COORD_W-1:0] BOX_MIN_RST = 32'h0000_0000;
  localparam logic [COORD_W-1:0] BOX_MAX_RST = 32'h0001_0000;
  localparam logic [FRAC_W-1:0]  HALF_VOXEL  = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               vld;
    logic               smp;
    logic [5:0]         wx;
    logic [5:0]         wy;
    logic [3:0]         wz;
    logic [VOXEL_W-1:0] wdata;
  } ctl_t;

endpackage

FILE: hdl/trilinear_volume_sampler_core.sv
// Top level of the trilinear volume sampler: box mapping, pipelined divider,
// banked voxel memory and the trilinear blend pipeline.
// Depends on tsv_pkg.

// A new command beat is taken on every clock (busy is only high during reset), and
// the block never stalls because the receiver cannot hold results off. Voxel writes
// produce no result. Every sample beat produces exactly one result beat, marked by
// done for a single cycle. Each coordinate is mapped into voxel space by a restoring
// divider with one quotient bit per pipeline stage; QW = clog2(max grid size) + 17
// is the number of quotient bits. Before the divider stages come the input capture,
// the box offset stage and the divider load; after them come the index stage, the
// memory read, the corner select, three multiply stages of the blend and the output
// register. The voxel store is split into eight banks by the parity of x, y and z,
// so the eight neighbors of a point are read in the same cycle. A voxel write lands
// in memory at the same pipeline stage where samples read, so writes and samples
// take effect in issue order.
// The store is not cleared: only voxels that were written may be sampled. Writes to
// the box registers are only allowed while no sample is in flight.
module trilinear_volume_sampler_core import tsv_pkg::*; #(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic [5:0]           voxel_x,
  input  logic [5:0]           voxel_y,
  input  logic [3:0]           voxel_z,
  input  logic [SAMPLE_W-1:0]  density_in,
  input  logic [SAMPLE_W-1:0]  temperature_in,
  input  logic [COORD_W-1:0]   point_x,
  input  logic [COORD_W-1:0]   point_y,
  input  logic [COORD_W-1:0]   point_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output logic                 done,
  output logic [SAMPLE_W-1:0]  density_out,
  output logic [SAMPLE_W-1:0]  temperature_out,
  output logic                 inside_res
);

  localparam int GMAX0 = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GMAX  = (GMAX0 > GRID_Z) ? GMAX0 : GRID_Z;
  localparam int GBW   = $clog2(GMAX + 1);
  localparam int QW    = $clog2(GMAX) + FRAC_W + 1;
  localparam int SH    = QW - FRAC_W;
  localparam int MW    = COORD_W + GBW;
  localparam int HIW   = QW + 1 - FRAC_W;
  localparam int IW    = $clog2(GMAX);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int XH    = (XW > 1) ? XW - 1 : 1;
  localparam int YH    = (YW > 1) ? YW - 1 : 1;
  localparam int ZH    = (ZW > 1) ? ZW - 1 : 1;
  localparam int AW    = XH + YH + ZH;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int LAT   = QW + 10;
  localparam int GA [3] = '{GRID_X, GRID_Y, GRID_Z};

  // The pipeline never applies backpressure.
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Box registers.
  logic [COORD_W-1:0] box_min [3];
  logic [COORD_W-1:0] box_max [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= BOX_MIN_RST;
        box_max[a] <= BOX_MAX_RST;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_X: box_min[0] <= cfg_data;
        REG_MIN_Y: box_min[1] <= cfg_data;
        REG_MIN_Z: box_min[2] <= cfg_data;
        REG_MAX_X: box_max[0] <= cfg_data;
        REG_MAX_Y: box_max[1] <= cfg_data;
        REG_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: capture the command beat. Nothing is accepted while busy, which
  // covers reset.
  ctl_t               s1_c;
  logic [COORD_W-1:0] s1_p [3];

  always_ff @(posedge clk) begin
    s1_c.vld   <= start && !busy;
    s1_c.smp   <= command;
    s1_c.wx    <= voxel_x;
    s1_c.wy    <= voxel_y;
    s1_c.wz    <= voxel_z;
    s1_c.wdata <= {temperature_in, density_in};
    s1_p[0]    <= point_x;
    s1_p[1]    <= point_y;
    s1_p[2]    <= point_z;
  end

  // Stage 2: offset from the box minimum, box extent and the inside test.
  ctl_t               s2_c;
  logic [COORD_W-1:0] s2_off [3];
  logic [COORD_W-1:0] s2_ext [3];
  logic               s2_in;
  logic [COORD_W:0]   off_c  [3];
  logic [COORD_W:0]   ext_c  [3];
  logic [2:0]         in_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off_c[a] = {s1_p[a][COORD_W-1], s1_p[a]} - {box_min[a][COORD_W-1], box_min[a]};
      ext_c[a] = {box_max[a][COORD_W-1], box_max[a]} - {box_min[a][COORD_W-1], box_min[a]};
      in_c[a]  = ($signed(box_max[a]) > $signed(box_min[a])) &&
                 ($signed(s1_p[a]) >= $signed(box_min[a])) &&
                 ($signed(s1_p[a]) <= $signed(box_max[a]));
    end
  end

  always_ff @(posedge clk) begin
    s2_c  <= rst ? '0 : s1_c;
    s2_in <= &in_c;
    for (int a = 0; a < 3; a++) begin
      s2_off[a] <= off_c[a][COORD_W-1:0];
      s2_ext[a] <= ext_c[a][COORD_W-1:0];
    end
  end

  // Divider: q = floor(off * G * 2^16 / ext), one quotient bit per stage.
  // Stage dv[0] holds the scaled offset split into a partial remainder and the
  // dividend bits still to be shifted in; quotient bits fill d from the bottom.
  ctl_t               dv_c  [QW+1];
  logic               dv_in [QW+1];
  logic [COORD_W-1:0] dv_r  [QW+1][3];
  logic [QW-1:0]      dv_d  [QW+1][3];
  logic [COORD_W-1:0] dv_e  [QW+1][3];
  logic [FRAC_W-1:0]  dv_pad;
  logic [MW-1:0]      m_c   [3];

  assign dv_pad = '0;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      m_c[a] = MW'(s2_off[a]) * MW'(GA[a]);
    end
  end

  always_ff @(posedge clk) begin
    dv_c[0]  <= rst ? '0 : s2_c;
    dv_in[0] <= s2_in;
    for (int a = 0; a < 3; a++) begin
      dv_r[0][a] <= COORD_W'(m_c[a] >> SH);
      dv_d[0][a] <= {m_c[a][SH-1:0], dv_pad};
      dv_e[0][a] <= s2_ext[a];
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [COORD_W:0]   t_c  [3];
    logic               ge_c [3];
    logic [COORD_W-1:0] r_c  [3];

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        t_c[a]  = {dv_r[k-1][a], dv_d[k-1][a][QW-1]};
        ge_c[a] = t_c[a] >= {1'b0, dv_e[k-1][a]};
        r_c[a]  = ge_c[a] ? COORD_W'(t_c[a] - {1'b0, dv_e[k-1][a]})
                          : COORD_W'(t_c[a]);
      end
    end

    always_ff @(posedge clk) begin
      dv_c[k]  <= rst ? '0 : dv_c[k-1];
      dv_in[k] <= dv_in[k-1];
      for (int a = 0; a < 3; a++) begin
        dv_r[k][a] <= r_c[a];
        dv_d[k][a] <= {dv_d[k-1][a][QW-2:0], ge_c[a]};
        dv_e[k][a] <= dv_e[k-1][a];
      end
    end
  end

  // Index stage: subtract half a voxel, split into base and fraction, clamp.
  ctl_t              ix_c;
  logic              ix_in;
  logic [IW-1:0]     ix_i0 [3];
  logic [IW-1:0]     ix_i1 [3];
  logic [FRAC_W-1:0] ix_f  [3];
  logic [QW:0]       sv_c  [3];
  logic [HIW-1:0]    hi_c  [3];
  logic [HIW-1:0]    lim_c [3];
  logic [IW-1:0]     i0_c  [3];
  logic [IW-1:0]     i1_c  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sv_c[a]  = {1'b0, dv_d[QW][a]} + (QW+1)'(HALF_VOXEL);
      hi_c[a]  = sv_c[a][QW:FRAC_W];
      lim_c[a] = HIW'(GA[a] - 1);
      i1_c[a]  = (hi_c[a] > lim_c[a]) ? IW'(lim_c[a]) : IW'(hi_c[a]);
      if (hi_c[a] == '0) begin
        i0_c[a] = '0;
      end else if (hi_c[a] - HIW'(1) > lim_c[a]) begin
        i0_c[a] = IW'(lim_c[a]);
      end else begin
        i0_c[a] = IW'(hi_c[a] - HIW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    ix_c  <= rst ? '0 : dv_c[QW];
    ix_in <= dv_in[QW];
    for (int a = 0; a < 3; a++) begin
      ix_i0[a] <= i0_c[a];
      ix_i1[a] <= i1_c[a];
      ix_f[a]  <= sv_c[a][FRAC_W-1:0];
    end
  end

  // Memory stage: eight banks selected by the parity of each index. Neighbors
  // v and v+1 always differ in parity unless clamping made them equal, in which
  // case both corners read the same bank.
  logic [IW-1:0]      pick_c [3][2];
  logic [AW-1:0]      raddr_c [8];
  logic [AW-1:0]      waddr_c;
  logic [2:0]         wbank_c;
  logic               wen_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int p = 0; p < 2; p++) begin
        pick_c[a][p] = (ix_i0[a][0] == p[0]) ? ix_i0[a] : ix_i1[a];
      end
    end
    for (int b = 0; b < 8; b++) begin
      raddr_c[b] = {ZH'(pick_c[2][b/4] >> 1), YH'(pick_c[1][(b/2)%2] >> 1),
                    XH'(pick_c[0][b%2] >> 1)};
    end
    waddr_c = {ZH'(ix_c.wz >> 1), YH'(ix_c.wy >> 1), XH'(ix_c.wx >> 1)};
    wbank_c = {ix_c.wz[0], ix_c.wy[0], ix_c.wx[0]};
    wen_c   = ix_c.vld && (ix_c.smp == CMD_WRITE) &&
              (int'(ix_c.wx) < GRID_X) && (int'(ix_c.wy) < GRID_Y) &&
              (int'(ix_c.wz) < GRID_Z);
  end

  logic [VOXEL_W-1:0] rd_q [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [VOXEL_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wen_c && (wbank_c == 3'(b))) begin
        mem[waddr_c] <= ix_c.wdata;
      end
      rd_q[b] <= mem[raddr_c[b]];
    end
  end

  ctl_t              rd_c;
  logic              rd_in;
  logic [1:0]        rd_par [3];
  logic [FRAC_W-1:0] rd_f   [3];

  always_ff @(posedge clk) begin
    rd_c  <= rst ? '0 : ix_c;
    rd_in <= ix_in;
    for (int a = 0; a < 3; a++) begin
      rd_par[a] <= {ix_i1[a][0], ix_i0[a][0]};
      rd_f[a]   <= ix_f[a];
    end
  end

  // Corner stage: corner {cz, cy, cx} comes from the bank of its index parity.
  ctl_t               co_c;
  logic               co_in;
  logic [FRAC_W-1:0]  co_f [3];
  logic [VOXEL_W-1:0] co_v [8];
  logic [2:0]         cb_c [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      cb_c[c] = {rd_par[2][c/4], rd_par[1][(c/2)%2], rd_par[0][c%2]};
    end
  end

  always_ff @(posedge clk) begin
    co_c  <= rst ? '0 : rd_c;
    co_in <= rd_in;
    co_f  <= rd_f;
    for (int c = 0; c < 8; c++) begin
      co_v[c] <= rd_q[cb_c[c]];
    end
  end

  // Row stage: blend along x, a*2^16 + (b - a)*fx, exact in 32 bits.
  ctl_t               rw_c;
  logic               rw_in;
  logic [FRAC_W-1:0]  rw_f [3];
  logic [31:0]        rw_v [2][4];
  logic signed [16:0] rdif_c [2][4];
  logic signed [33:0] rsum_c [2][4];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      for (int r = 0; r < 4; r++) begin
        rdif_c[f][r] = $signed({1'b0, co_v[2*r+1][SAMPLE_W*f +: SAMPLE_W]}) -
                       $signed({1'b0, co_v[2*r][SAMPLE_W*f +: SAMPLE_W]});
        rsum_c[f][r] = $signed({2'b0, co_v[2*r][SAMPLE_W*f +: SAMPLE_W], dv_pad}) +
                       rdif_c[f][r] * $signed({1'b0, co_f[0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    rw_c  <= rst ? '0 : co_c;
    rw_in <= co_in;
    rw_f  <= co_f;
    for (int f = 0; f < 2; f++) begin
      for (int r = 0; r < 4; r++) begin
        rw_v[f][r] <= rsum_c[f][r][31:0];
      end
    end
  end

  // Plane stage: blend along y, exact in 48 bits.
  ctl_t               pl_c;
  logic               pl_in;
  logic [FRAC_W-1:0]  pl_fz;
  logic [47:0]        pl_v [2][2];
  logic signed [32:0] pdif_c [2][2];
  logic signed [49:0] psum_c [2][2];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < 2; k++) begin
        pdif_c[f][k] = $signed({1'b0, rw_v[f][2*k+1]}) - $signed({1'b0, rw_v[f][2*k]});
        psum_c[f][k] = $signed({2'b0, rw_v[f][2*k], dv_pad}) +
                       pdif_c[f][k] * $signed({1'b0, rw_f[1]});
      end
    end
  end

  always_ff @(posedge clk) begin
    pl_c  <= rst ? '0 : rw_c;
    pl_in <= rw_in;
    pl_fz <= rw_f[2];
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < 2; k++) begin
        pl_v[f][k] <= psum_c[f][k][47:0];
      end
    end
  end

  // Partial product stage: the z blend difference is 49 bits, so it is split
  // into a high and a low half, each multiplied by fz.
  ctl_t               pt_c;
  logic               pt_in;
  logic [47:0]        pt_base [2];
  logic [39:0]        pt_lo   [2];
  logic signed [41:0] pt_hi   [2];
  logic signed [48:0] zdif_c  [2];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      zdif_c[f] = $signed({1'b0, pl_v[f][1]}) - $signed({1'b0, pl_v[f][0]});
    end
  end

  always_ff @(posedge clk) begin
    pt_c  <= rst ? '0 : pl_c;
    pt_in <= pl_in;
    for (int f = 0; f < 2; f++) begin
      pt_base[f] <= pl_v[f][0];
      pt_lo[f]   <= zdif_c[f][23:0] * pl_fz;
      pt_hi[f]   <= $signed(zdif_c[f][48:24]) * $signed({1'b0, pl_fz});
    end
  end

  // Final sum; the value is the top 16 bits of a 64-bit exact result.
  logic [63:0] tot_c [2];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      tot_c[f] = {pt_base[f], dv_pad} + ({{22{pt_hi[f][41]}}, pt_hi[f]} << 24) +
                 {24'b0, pt_lo[f]};
    end
  end

  always_ff @(posedge clk) begin
    done            <= !rst && pt_c.vld && (pt_c.smp == CMD_SAMPLE);
    inside_res      <= pt_in;
    density_out     <= pt_in ? tot_c[0][63:48] : '0;
    temperature_out <= pt_in ? tot_c[1][63:48] : '0;
  end

  // Every accepted sample yields its result a fixed latency later.
  a_sample_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_SAMPLE |-> ##LAT done)
    else $error("sample beat without result");

  // No result appears unless a sample was accepted that latency earlier.
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && command == CMD_SAMPLE, LAT))
    else $error("result beat without sample");

  // An outside point reports zero for both fields.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    done && !inside_res |-> density_out == '0 && temperature_out == '0)
    else $error("outside result not zero");

  // Clamped neighbor indices stay ordered on every axis.
  a_idx_order: assert property (@(posedge clk) disable iff (rst)
    ix_c.vld |-> ix_i0[0] <= ix_i1[0] && ix_i0[1] <= ix_i1[1] && ix_i0[2] <= ix_i1[2])
    else $error("neighbor indices out of order");

endmodule
